// ----- rtl/pwd_pkg.sv -----
package pwd_pkg;

  localparam int unsigned MaxStepsDefault = 63;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DeltaW = 33;
  localparam int unsigned MagW = 32;
  localparam int unsigned SqW = 67;
  localparam int unsigned RootW = 34;
  localparam int unsigned SpacingW = 31;
  localparam logic [SpacingW-1:0] SpacingReset = 31'd65536;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     fin;
  } wp_t;

  // front to back: a segment to walk, or only a final point
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [DeltaW-1:0] dz;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ez;
    logic [5:0]               n;
    logic                     clip;
    logic                     fin;
  } seg_t;

endpackage

// ----- rtl/path_waypoint_densifier_core.sv -----
// Steps: the front squares each axis of an accepted waypoint's delta, takes the root
// and divides by spacing, hands the segment off, then the back multiplies and divides
// per axis and outputs each point; a waypoint with no previous one skips the arithmetic.
// The front takes no new waypoint until its segment is handed off, running ahead of
// the point stream through a two-entry queue.
// Reset: rst_n synchronous active low; clears previous waypoint, spacing=65536.
module path_waypoint_densifier_core #(
  parameter int unsigned MAX_STEPS = pwd_pkg::MaxStepsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_spacing,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_wp_x,
  input  logic signed [31:0] in_wp_y,
  input  logic signed [31:0] in_wp_z,
  input  logic        in_final_wp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_pt_x,
  output logic signed [31:0] out_pt_y,
  output logic signed [31:0] out_pt_z,
  output logic        out_path_end,
  output logic        out_clipped
);

  logic [pwd_pkg::SpacingW-1:0] spacing_r;
  pwd_pkg::wp_t wp;
  pwd_pkg::seg_t f_seg, b_seg;
  logic f_v, f_s, b_v, b_s;

  always_ff @(posedge clk) begin
    if (!rst_n) spacing_r <= pwd_pkg::SpacingReset;
    else if (cfg_we) spacing_r <= cfg_spacing;
  end

  assign wp.x = in_wp_x;
  assign wp.y = in_wp_y;
  assign wp.z = in_wp_z;
  assign wp.fin = in_final_wp;

  pwd_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk, .rst_n, .spacing(spacing_r),
    .wp_valid(in_valid), .wp_stall(in_stall), .wp,
    .seg_valid(f_v), .seg_stall(f_s), .seg(f_seg)
  );

  pwd_queue u_queue (
    .clk, .rst_n,
    .in_valid(f_v), .in_stall(f_s), .in_data(f_seg),
    .out_valid(b_v), .out_stall(b_s), .out_data(b_seg)
  );

  pwd_back u_back (
    .clk, .rst_n,
    .seg_valid(b_v), .seg_stall(b_s), .seg(b_seg),
    .out_valid, .out_stall,
    .pt_x(out_pt_x), .pt_y(out_pt_y), .pt_z(out_pt_z),
    .pt_end(out_path_end), .pt_clip(out_clipped)
  );

endmodule

// ----- rtl/pwd_front.sv -----
module pwd_front #(
  parameter int unsigned MAX_STEPS = pwd_pkg::MaxStepsDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pwd_pkg::SpacingW-1:0]   spacing,
  input  logic                           wp_valid,
  output logic                           wp_stall,
  input  pwd_pkg::wp_t                   wp,
  output logic                           seg_valid,
  input  logic                           seg_stall,
  output pwd_pkg::seg_t                  seg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sqc_r;
  logic [5:0] cnt_r;
  logic [pwd_pkg::CoordW-1:0] prx_r, pry_r, prz_r;
  logic have_r;
  pwd_pkg::seg_t seg_r;
  logic [pwd_pkg::SqW-1:0] sq_r;
  logic [pwd_pkg::SqW-1:0] rem_r;
  logic [pwd_pkg::RootW-1:0] root_r;
  logic [pwd_pkg::RootW-1:0] quo_r;
  logic [pwd_pkg::RootW:0]   drem_r;
  logic [pwd_pkg::SpacingW-1:0] sp_r;

  logic [pwd_pkg::MagW-1:0] mag_sel;
  logic signed [pwd_pkg::DeltaW-1:0] d_sel;
  logic [63:0] prod;
  logic [pwd_pkg::SqW-1:0] trial, rem_sub;
  logic [pwd_pkg::RootW:0] dshift;
  logic qbit;
  logic [pwd_pkg::RootW-1:0] quo_nxt;

  assign wp_stall  = (state_r != S_IDLE);
  assign seg_valid = (state_r == S_OUT);
  assign seg       = seg_r;

  always_comb begin
    unique case (sqc_r)
      2'd0:    d_sel = seg_r.dx;
      2'd1:    d_sel = seg_r.dy;
      default: d_sel = seg_r.dz;
    endcase
    mag_sel = d_sel[pwd_pkg::DeltaW-1] ? pwd_pkg::MagW'(-d_sel) : pwd_pkg::MagW'(d_sel);
    prod = 64'(mag_sel) * 64'(mag_sel);
    // restoring square root, one result bit per cycle
    trial = ((pwd_pkg::SqW)'(root_r) << (cnt_r + 6'd1)) |
            ((pwd_pkg::SqW)'(1) << {cnt_r, 1'b0});
    rem_sub = rem_r - trial;
    dshift = {drem_r[pwd_pkg::RootW-1:0], root_r[pwd_pkg::RootW-1]};
    qbit = (dshift >= (pwd_pkg::RootW+1)'(sp_r));
    quo_nxt = {quo_r[pwd_pkg::RootW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      have_r  <= 1'b0;
      prx_r <= '0;
      pry_r <= '0;
      prz_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && wp_valid) begin
        have_r <= !wp.fin;
        prx_r <= wp.x;
        pry_r <= wp.y;
        prz_r <= wp.z;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (wp_valid) state_nxt = have_r ? S_SQ : S_OUT;
      S_SQ:   if (sqc_r == 2'd2) state_nxt = S_ROOT;
      S_ROOT: if (cnt_r == 6'd0) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd0) state_nxt = S_OUT;
      S_OUT:  if (!seg_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        seg_r.px <= prx_r;
        seg_r.py <= pry_r;
        seg_r.pz <= prz_r;
        seg_r.dx <= pwd_pkg::DeltaW'(wp.x) - pwd_pkg::DeltaW'(signed'(prx_r));
        seg_r.dy <= pwd_pkg::DeltaW'(wp.y) - pwd_pkg::DeltaW'(signed'(pry_r));
        seg_r.dz <= pwd_pkg::DeltaW'(wp.z) - pwd_pkg::DeltaW'(signed'(prz_r));
        seg_r.ex <= wp.x;
        seg_r.ey <= wp.y;
        seg_r.ez <= wp.z;
        seg_r.fin <= wp.fin;
        seg_r.n <= '0;
        seg_r.clip <= 1'b0;
        sq_r <= '0;
        sqc_r <= '0;
        sp_r <= (spacing == '0) ? pwd_pkg::SpacingW'(1) : spacing;
      end
      S_SQ: begin
        sq_r <= sq_r + pwd_pkg::SqW'(prod);
        sqc_r <= sqc_r + 2'd1;
        if (sqc_r == 2'd2) begin
          rem_r <= sq_r + pwd_pkg::SqW'(prod);
          root_r <= '0;
          cnt_r <= 6'(pwd_pkg::RootW - 1);
        end
      end
      S_ROOT: begin
        if (!rem_sub[pwd_pkg::SqW-1] && rem_r >= trial) begin
          rem_r <= rem_sub;
          root_r <= root_r | (pwd_pkg::RootW'(1) << cnt_r);
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          drem_r <= '0;
          quo_r <= '0;
          cnt_r <= 6'(pwd_pkg::RootW - 1);
        end
      end
      S_DIV: begin
        // restoring divide len / spacing, root_r shifts out MSB first
        root_r <= {root_r[pwd_pkg::RootW-2:0], 1'b0};
        if (qbit) begin
          drem_r <= dshift - (pwd_pkg::RootW+1)'(sp_r);
        end else begin
          drem_r <= dshift;
        end
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (quo_nxt > pwd_pkg::RootW'(MAX_STEPS)) begin
            seg_r.n <= 6'(MAX_STEPS);
            seg_r.clip <= 1'b1;
          end else begin
            seg_r.n <= quo_nxt[5:0];
          end
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- rtl/pwd_queue.sv -----
module pwd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pwd_pkg::seg_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pwd_pkg::seg_t out_data
);

  pwd_pkg::seg_t m_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = m_r[rp_r];
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) m_r[wp_r] <= in_data;
  end

endmodule

// ----- rtl/pwd_back.sv -----
module pwd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            seg_valid,
  output logic                            seg_stall,
  input  pwd_pkg::seg_t                   seg,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pwd_pkg::CoordW-1:0] pt_x,
  output logic signed [pwd_pkg::CoordW-1:0] pt_y,
  output logic signed [pwd_pkg::CoordW-1:0] pt_z,
  output logic                            pt_end,
  output logic                            pt_clip
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_OUT  = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;
  localparam int unsigned PW = 39;

  logic [2:0] st_r;
  pwd_pkg::seg_t s_r;
  logic [5:0] j_r, bit_r;
  logic [1:0] ax_r;
  logic [PW-1:0] num_r [3];
  logic neg_r [3];
  logic [PW-1:0] q_r [3];
  logic [6:0] rem_r;
  logic [pwd_pkg::CoordW-1:0] ox_r, oy_r, oz_r;
  logic oend_r, oclip_r, ov_r;
  logic signed [pwd_pkg::DeltaW-1:0] d_sel;
  logic [PW-1:0] m_sel;
  logic [PW-1:0] prd;
  logic [6:0] rsh;
  logic [PW-1:0] qs [3];
  logic [pwd_pkg::CoordW-1:0] sum [3];

  assign seg_stall = (st_r != B_IDLE);
  assign out_valid = ov_r;
  assign pt_x = ox_r;
  assign pt_y = oy_r;
  assign pt_z = oz_r;
  assign pt_end = oend_r;
  assign pt_clip = oclip_r;

  always_comb begin
    unique case (ax_r)
      2'd0:    d_sel = s_r.dx;
      2'd1:    d_sel = s_r.dy;
      default: d_sel = s_r.dz;
    endcase
    m_sel = d_sel[pwd_pkg::DeltaW-1] ? PW'(-d_sel) : PW'(d_sel);
    prd = PW'(m_sel * PW'(j_r));
    rsh = {rem_r[5:0], num_r[ax_r][bit_r]};
    for (int k = 0; k < 3; k++) begin
      qs[k] = neg_r[k] ? -q_r[k] : q_r[k];
    end
    sum[0] = s_r.px + qs[0][pwd_pkg::CoordW-1:0];
    sum[1] = s_r.py + qs[1][pwd_pkg::CoordW-1:0];
    sum[2] = s_r.pz + qs[2][pwd_pkg::CoordW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall && st_r != B_OUT && st_r != B_FIN) ov_r <= 1'b0;
      unique case (st_r)
        B_IDLE: if (seg_valid) begin
          s_r <= seg;
          j_r <= '0;
          ax_r <= '0;
          st_r <= (seg.n == '0) ? (seg.fin ? B_FIN : B_IDLE) : B_MUL;
        end
        B_MUL: begin
          // one axis per cycle: |d|*j
          num_r[ax_r] <= prd;
          neg_r[ax_r] <= d_sel[pwd_pkg::DeltaW-1];
          q_r[ax_r] <= '0;
          if (ax_r == 2'd2) begin
            ax_r <= '0;
            bit_r <= 6'(PW - 1);
            rem_r <= '0;
            st_r <= B_DIV;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end
        B_DIV: begin
          if (rsh >= {1'b0, s_r.n}) begin
            rem_r <= rsh - {1'b0, s_r.n};
            q_r[ax_r] <= {q_r[ax_r][PW-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            q_r[ax_r] <= {q_r[ax_r][PW-2:0], 1'b0};
          end
          bit_r <= bit_r - 6'd1;
          if (bit_r == 6'd0) begin
            bit_r <= 6'(PW - 1);
            rem_r <= '0;
            if (ax_r == 2'd2) st_r <= B_OUT;
            else ax_r <= ax_r + 2'd1;
          end
        end
        B_OUT: if (!ov_r || !out_stall) begin
          ov_r <= 1'b1;
          ox_r <= sum[0];
          oy_r <= sum[1];
          oz_r <= sum[2];
          oend_r <= 1'b0;
          oclip_r <= s_r.clip;
          ax_r <= '0;
          j_r <= j_r + 6'd1;
          if (j_r + 6'd1 == s_r.n) st_r <= s_r.fin ? B_FIN : B_IDLE;
          else st_r <= B_MUL;
        end
        B_FIN: if (!ov_r || !out_stall) begin
          ov_r <= 1'b1;
          ox_r <= s_r.ex;
          oy_r <= s_r.ey;
          oz_r <= s_r.ez;
          oend_r <= 1'b1;
          oclip_r <= s_r.clip;
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(ox_r) && $stable(oend_r))
    else $error("output beat changed while stalled");
  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV) |-> s_r.n != '0)
    else $error("divide by zero step count");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FIN) |-> s_r.fin)
    else $error("final beat without final waypoint");
`endif

endmodule

// ----- test/path_waypoint_densifier_core_tb.sv -----
`timescale 1ns / 1ps

module path_waypoint_densifier_core_tb;

  localparam int unsigned MaxSteps = 63;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               fin;
  } wp_beat_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               path_end;
    logic               clipped;
  } pt_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_spacing = pwd_pkg::SpacingReset;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_wp_x = '0;
  logic signed [31:0] in_wp_y = '0;
  logic signed [31:0] in_wp_z = '0;
  logic in_final_wp = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pt_x;
  logic signed [31:0] out_pt_y;
  logic signed [31:0] out_pt_z;
  logic out_path_end;
  logic out_clipped;

  path_waypoint_densifier_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_spacing(cfg_spacing),
    .in_valid(in_valid), .in_stall(in_stall), .in_wp_x(in_wp_x),
    .in_wp_y(in_wp_y), .in_wp_z(in_wp_z), .in_final_wp(in_final_wp),
    .out_valid(out_valid), .out_stall(out_stall), .out_pt_x(out_pt_x),
    .out_pt_y(out_pt_y), .out_pt_z(out_pt_z), .out_path_end(out_path_end),
    .out_clipped(out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wp_beat_t wp_pending[$];
  pt_beat_t pt_expected[$];
  int unsigned n_fail = 0;
  int unsigned n_points = 0;
  int unsigned n_clipped = 0;
  int unsigned n_wp = 0;
  int unsigned hold_cnt = 0;
  bit send_pause = 1'b0;

  // predictor state
  logic [30:0] spacing_q = pwd_pkg::SpacingReset;
  logic signed [31:0] last_x = '0, last_y = '0, last_z = '0;
  bit holding = 1'b0;

  function automatic logic [33:0] root67(logic [66:0] v);
    logic [33:0] r;
    logic [33:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (34'd1 << b);
      if ({34'd0, t} * {34'd0, t} <= {1'b0, v}) r = t;
    end
    return r;
  endfunction

  task automatic densify(input wp_beat_t w);
    logic signed [33:0] dx, dy, dz;
    logic [32:0] ax, ay, az;
    logic [66:0] sq;
    logic [33:0] len;
    logic [33:0] steps;
    logic [30:0] sp;
    logic clip;
    pt_beat_t p;
    longint signed jj;
    clip = 1'b0;
    if (holding) begin
      dx = 34'(w.x) - 34'(last_x);
      dy = 34'(w.y) - 34'(last_y);
      dz = 34'(w.z) - 34'(last_z);
      ax = 33'(dx < 0 ? -dx : dx);
      ay = 33'(dy < 0 ? -dy : dy);
      az = 33'(dz < 0 ? -dz : dz);
      sq = 67'(ax) * 67'(ax) + 67'(ay) * 67'(ay) + 67'(az) * 67'(az);
      len = root67(sq);
      sp = (spacing_q == 0) ? 31'd1 : spacing_q;
      steps = len / 34'(sp);
      if (steps > 34'(MaxSteps)) begin
        steps = 34'(MaxSteps);
        clip = 1'b1;
      end
      for (int j = 0; j < int'(steps); j++) begin
        jj = j;
        p.x = 32'(64'(last_x) + (jj * 64'(dx)) / longint'(steps));
        p.y = 32'(64'(last_y) + (jj * 64'(dy)) / longint'(steps));
        p.z = 32'(64'(last_z) + (jj * 64'(dz)) / longint'(steps));
        p.path_end = 1'b0;
        p.clipped = clip;
        pt_expected.insert(pt_expected.size(), p);
      end
    end
    if (w.fin) begin
      p.x = w.x;
      p.y = w.y;
      p.z = w.z;
      p.path_end = 1'b1;
      p.clipped = clip;
      pt_expected.insert(pt_expected.size(), p);
    end
    holding = !w.fin;
    last_x = w.x;
    last_y = w.y;
    last_z = w.z;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sender
  int unsigned tx_gap = 0;
  bit tx_busy = 1'b0;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      wp_beat_t w;
      w.x = in_wp_x;
      w.y = in_wp_y;
      w.z = in_wp_z;
      w.fin = in_final_wp;
      densify(w);
      n_wp++;
      void'(wp_pending.pop_front());
      tx_gap = gap_len();
      tx_busy = 1'b0;
    end
  end
  always @(negedge clk) begin
    if (!tx_busy) begin
      if (!rst_n || send_pause || wp_pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else begin
        in_valid <= 1'b1;
        in_wp_x <= wp_pending[0].x;
        in_wp_y <= wp_pending[0].y;
        in_wp_z <= wp_pending[0].z;
        in_final_wp <= wp_pending[0].fin;
        tx_busy = 1'b1;
      end
    end
  end

  // receiver
  int unsigned rx_gap = 0;
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (rx_gap != 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      rx_gap = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pt_beat_t e;
      n_points++;
      if (pt_expected.size() == 0) begin
        $error("unexpected point beat x=%0d y=%0d z=%0d", out_pt_x, out_pt_y, out_pt_z);
        n_fail++;
      end else begin
        e = pt_expected.pop_front();
        if (out_clipped) n_clipped++;
        if (out_pt_x !== e.x) begin
          $error("pt_x expected %0d got %0d", e.x, out_pt_x);
          n_fail++;
        end
        if (out_pt_y !== e.y) begin
          $error("pt_y expected %0d got %0d", e.y, out_pt_y);
          n_fail++;
        end
        if (out_pt_z !== e.z) begin
          $error("pt_z expected %0d got %0d", e.z, out_pt_z);
          n_fail++;
        end
        if (out_path_end !== e.path_end) begin
          $error("path_end expected %0d got %0d", e.path_end, out_path_end);
          n_fail++;
        end
        if (out_clipped !== e.clipped) begin
          $error("clipped expected %0d got %0d", e.clipped, out_clipped);
          n_fail++;
        end
      end
    end
  end

  task automatic push_wp(input logic signed [31:0] x, input logic signed [31:0] y,
                         input logic signed [31:0] z, input logic fin);
    wp_beat_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    w.fin = fin;
    wp_pending.insert(wp_pending.size(), w);
  endtask

  task automatic drain();
    while (wp_pending.size() != 0 || in_valid || pt_expected.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_spacing(input logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_spacing <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    spacing_q = v;
  endtask

  function automatic logic signed [31:0] rnd_coord(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  task automatic rnd_path(input int unsigned len, input int unsigned span);
    logic signed [31:0] bx, by, bz;
    bx = rnd_coord(32'h4000_0000);
    by = rnd_coord(32'h4000_0000);
    bz = rnd_coord(32'h4000_0000);
    for (int i = 0; i < len; i++) begin
      push_wp(bx, by, bz, i == len - 1);
      bx = bx + rnd_coord(span);
      by = by + rnd_coord(span);
      bz = bz + rnd_coord(span);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset spacing: final-only, zero step, clipped, short segments
    push_wp(32'sd0, 32'sd0, 32'sd0, 1'b1);
    push_wp(32'sd100, 32'sd0, 32'sd0, 1'b0);
    push_wp(32'sd200, 32'sd0, 32'sd0, 1'b0);
    push_wp(32'sd200 + 32'sd262144, -32'sd196608, 32'sd65536, 1'b0);
    push_wp(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_wp(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    push_wp(32'h80000000, 32'h7fffffff, 32'h0, 1'b0);
    push_wp(32'h80000000, 32'h7fffffff, 32'h0, 1'b1);
    push_wp(-32'sd5, 32'sd7, -32'sd9, 1'b0);
    push_wp(-32'sd5 + 32'sd700000, 32'sd7, -32'sd9 - 32'sd300000, 1'b1);
    drain();

    set_spacing(31'd0);
    push_wp(32'sd0, 32'sd0, 32'sd0, 1'b0);
    push_wp(32'sd1, 32'sd0, 32'sd0, 1'b0);
    push_wp(32'sd3, -32'sd2, 32'sd7, 1'b1);
    drain();

    set_spacing(31'h7fffffff);
    push_wp(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    push_wp(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_wp(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    drain();

    set_spacing(31'd1);
    push_wp(32'sd10, 32'sd20, 32'sd30, 1'b0);
    push_wp(32'sd17, 32'sd20, 32'sd30, 1'b0);
    push_wp(-32'sd40, 32'sd99, -32'sd3, 1'b1);
    drain();

    // long receiver hold so the block fills and stalls input
    set_spacing(31'd65536);
    hold_cnt = 3000;
    rnd_path(8, 32'h0003_0000);
    while (hold_cnt != 0) @(posedge clk);
    drain();

    // sender pause until all results are out
    rnd_path(6, 32'h0008_0000);
    while (wp_pending.size() > 3) @(posedge clk);
    send_pause = 1'b1;
    while (pt_expected.size() != 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
    send_pause = 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_spacing(31'd65536);
        1: set_spacing(31'($urandom_range(1, 32'h0010_0000)));
        2: set_spacing(31'd16384);
        default: set_spacing(31'($urandom()));
      endcase
      while (wp_pending.size() < 70) begin
        if ($urandom_range(0, 9) == 0)
          push_wp($urandom(), $urandom(), $urandom(), 1'($urandom()));
        else
          rnd_path($urandom_range(1, 6), $urandom_range(1, 4) == 1 ?
                   32'h0100_0000 : 32'h0008_0000);
      end
      drain();
    end

    $display("%0d waypoints, %0d points checked (%0d clipped), spacing from 0 to max",
             n_wp, n_points, n_clipped);
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pwd_pkg.sv
rtl/pwd_front.sv
rtl/pwd_queue.sv
rtl/pwd_back.sv
rtl/path_waypoint_densifier_core.sv
test/path_waypoint_densifier_core_tb.sv
